### rtl/lobm_pkg.sv
// Package for the limit order book matcher: payload structs, result codes,
// controller/datapath command and status structs. No dependencies.
package lobm_pkg;

   localparam int ORDER_SLOTS_DEF = 64;
   localparam int MAX_RESULTS     = 64;
   localparam int TRADE_CAP       = MAX_RESULTS - 1;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_CANCEL = 2'd1;
   localparam logic [1:0] CMD_MODIFY = 2'd2;

   localparam logic [2:0] KIND_TRADE     = 3'd0;
   localparam logic [2:0] KIND_DONE      = 3'd1;
   localparam logic [2:0] KIND_DONE_KILL = 3'd2;
   localparam logic [2:0] KIND_DUP       = 3'd3;
   localparam logic [2:0] KIND_NO_CROSS  = 3'd4;
   localparam logic [2:0] KIND_FULL      = 3'd5;
   localparam logic [2:0] KIND_UNKNOWN   = 3'd6;
   localparam logic [2:0] KIND_ZERO_QTY  = 3'd7;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [31:0]        order_id;
      logic               side;
      logic               order_type;
      logic signed [31:0] price;
      logic [31:0]        quantity;
   } req_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [31:0]        bid_order_id;
      logic [31:0]        ask_order_id;
      logic signed [31:0] bid_price;
      logic signed [31:0] ask_price;
      logic [31:0]        fill_qty;
      logic               last;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic scan_start;   // begin one sweep over the table
      logic kill_found;   // clear the slot found by id
      logic place;        // write new order into first free slot
      logic trade;        // apply fill between best bid and best ask
      logic kill_new;     // clear the newly placed slot
      logic use_old_fok;  // modify: take type from the found order
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic scan_done;
      logic id_found;
      logic free_found;
      logic bid_found;
      logic ask_found;
      logic crossed;      // best bid price >= best ask price
      logic fok_cross;    // new order reaches best opposite
      logic new_valid;    // placed slot still resting
      logic is_fok;       // type of the command in hand
   } dp_sts_type;

endpackage

### rtl/lobm_datapath.sv
// Datapath of the order book matcher: slot table, serial scan unit
// and trade arithmetic. Depends on lobm_pkg.
module lobm_datapath #(
   parameter int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  lobm_pkg::req_type   req_in,
   input  lobm_pkg::dp_cmd_type cmd_in,
   output lobm_pkg::dp_sts_type sts_out,
   output lobm_pkg::rsp_type   trade_out
);
   import lobm_pkg::*;

   localparam int IW = $clog2(ORDER_SLOTS);

   logic [ORDER_SLOTS-1:0] valid_ff, valid_in;
   logic [31:0] oid_ff   [ORDER_SLOTS];
   logic        sell_ff  [ORDER_SLOTS];
   logic        fok_ff   [ORDER_SLOTS];
   logic [31:0] price_ff [ORDER_SLOTS];
   logic [31:0] rem_ff   [ORDER_SLOTS];
   logic [31:0] arr_ff   [ORDER_SLOTS];
   logic [31:0] arrival_ff;

   // scan state
   logic          busy_ff;
   logic [IW-1:0] idx_ff;
   logic          done_ff;
   logic          idf_ff, frf_ff, bf_ff, af_ff;
   logic [IW-1:0] ids_ff, frs_ff, bs_ff, as_ff, new_ff;
   logic [31:0]   bk_ff, ak_ff, barr_ff, aarr_ff;
   logic [31:0]   boid_ff, aoid_ff, bpx_ff, apx_ff, brem_ff, arem_ff;
   logic          idfok_ff;
   logic          cur_fok_ff;

   // registered table read, one slot a cycle
   logic          rd_go_ff, rd_last_ff, rd_valid_ff;
   logic [IW-1:0] rd_idx_ff;
   logic [31:0]   rd_oid_ff, rd_price_ff, rd_rem_ff, rd_arr_ff;
   logic          rd_sell_ff, rd_fok_ff;

   logic [31:0] k_cur, key_req;
   logic [31:0] q_min;
   logic        last_idx;

   assign k_cur    = rd_price_ff ^ 32'h8000_0000;
   assign key_req  = req_in.price ^ 32'h8000_0000;
   assign last_idx = (idx_ff == IW'(ORDER_SLOTS - 1));
   assign q_min    = (brem_ff < arem_ff) ? brem_ff : arem_ff;

   // step the read address across the table
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         idx_ff     <= '0;
         rd_go_ff   <= 1'b0;
         rd_last_ff <= 1'b0;
      end else begin
         rd_go_ff   <= busy_ff;
         rd_last_ff <= busy_ff && last_idx;
         if (cmd_in.scan_start) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (busy_ff) begin
            if (last_idx) begin
               busy_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + IW'(1);
            end
         end
      end
   end

   // track id hit, free slot, best bid and ask on the slot just read
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd_in.scan_start) begin
            idf_ff <= 1'b0;
            frf_ff <= 1'b0;
            bf_ff  <= 1'b0;
            af_ff  <= 1'b0;
         end else if (rd_go_ff) begin
            if (rd_valid_ff) begin
               if (rd_oid_ff == req_in.order_id && !idf_ff) begin
                  idf_ff   <= 1'b1;
                  ids_ff   <= rd_idx_ff;
                  idfok_ff <= rd_fok_ff;
               end
               if (!rd_sell_ff) begin
                  if (!bf_ff || k_cur > bk_ff ||
                      (k_cur == bk_ff && rd_arr_ff < barr_ff)) begin
                     bf_ff <= 1'b1; bs_ff <= rd_idx_ff;
                     bk_ff <= k_cur; barr_ff <= rd_arr_ff;
                     boid_ff <= rd_oid_ff; bpx_ff <= rd_price_ff; brem_ff <= rd_rem_ff;
                  end
               end else begin
                  if (!af_ff || k_cur < ak_ff ||
                      (k_cur == ak_ff && rd_arr_ff < aarr_ff)) begin
                     af_ff <= 1'b1; as_ff <= rd_idx_ff;
                     ak_ff <= k_cur; aarr_ff <= rd_arr_ff;
                     aoid_ff <= rd_oid_ff; apx_ff <= rd_price_ff; arem_ff <= rd_rem_ff;
                  end
               end
            end else if (!frf_ff) begin
               frf_ff <= 1'b1;
               frs_ff <= rd_idx_ff;
            end
            if (rd_last_ff) done_ff <= 1'b1;
         end
      end
   end

   // update valid bits
   always_comb begin
      valid_in = valid_ff;
      if (cmd_in.kill_found) valid_in[ids_ff] = 1'b0;
      if (cmd_in.place)      valid_in[frs_ff] = 1'b1;
      if (cmd_in.kill_new)   valid_in[new_ff] = 1'b0;
      if (cmd_in.trade) begin
         if (brem_ff == q_min) valid_in[bs_ff] = 1'b0;
         if (arem_ff == q_min) valid_in[as_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         arrival_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (cmd_in.place) arrival_ff <= arrival_ff + 32'd1;
      end
   end

   // hold type of the command: own type on add, old type on modify
   always_ff @(posedge clock) begin
      if (cmd_in.use_old_fok) cur_fok_ff <= idfok_ff;
      else if (done_ff && req_in.cmd == CMD_ADD) cur_fok_ff <= req_in.order_type;
   end

   // slot payload writes and the registered read of the scanned slot
   always_ff @(posedge clock) begin
      if (cmd_in.place) begin
         oid_ff[frs_ff]   <= req_in.order_id;
         sell_ff[frs_ff]  <= req_in.side;
         fok_ff[frs_ff]   <= cur_fok_ff;
         price_ff[frs_ff] <= req_in.price;
         rem_ff[frs_ff]   <= req_in.quantity;
         arr_ff[frs_ff]   <= arrival_ff;
         new_ff           <= frs_ff;
      end
      if (cmd_in.trade) begin
         rem_ff[bs_ff] <= brem_ff - q_min;
         rem_ff[as_ff] <= arem_ff - q_min;
      end
      rd_idx_ff   <= idx_ff;
      rd_valid_ff <= valid_ff[idx_ff];
      rd_oid_ff   <= oid_ff[idx_ff];
      rd_sell_ff  <= sell_ff[idx_ff];
      rd_fok_ff   <= fok_ff[idx_ff];
      rd_price_ff <= price_ff[idx_ff];
      rd_rem_ff   <= rem_ff[idx_ff];
      rd_arr_ff   <= arr_ff[idx_ff];
   end

   always_comb begin
      sts_out.scan_done  = done_ff;
      sts_out.id_found   = idf_ff;
      sts_out.free_found = frf_ff;
      sts_out.bid_found  = bf_ff;
      sts_out.ask_found  = af_ff;
      sts_out.crossed    = bf_ff && af_ff && (bk_ff >= ak_ff);
      sts_out.fok_cross  = req_in.side ? (bf_ff && key_req <= bk_ff)
                                       : (af_ff && key_req >= ak_ff);
      sts_out.new_valid  = valid_ff[new_ff];
      sts_out.is_fok     = cur_fok_ff;
      trade_out.kind         = KIND_TRADE;
      trade_out.bid_order_id = boid_ff;
      trade_out.ask_order_id = aoid_ff;
      trade_out.bid_price    = bpx_ff;
      trade_out.ask_price    = apx_ff;
      trade_out.fill_qty     = q_min;
      trade_out.last         = 1'b0;
   end

endmodule

### rtl/lobm_control.sv
// Controller of the order book matcher: command sequencing, result
// register and trade cap. Depends on lobm_pkg.
module lobm_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lobm_pkg::req_type    req_in,
   output lobm_pkg::req_type    req_held,
   output lobm_pkg::dp_cmd_type cmd_out,
   input  lobm_pkg::dp_sts_type sts_in,
   input  lobm_pkg::rsp_type    trade_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lobm_pkg::rsp_type    rsp_data
);
   import lobm_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN1 = 3'd1;  // id lookup and best prices
   localparam logic [2:0] ST_SCAN2 = 3'd2;  // add checks, after a rescan when a modified order was removed
   localparam logic [2:0] ST_MATCH = 3'd3;  // rescan for next trade
   localparam logic [2:0] ST_EMIT  = 3'd4;  // wait for result to drain
   localparam logic [2:0] ST_KICK  = 3'd5;  // start a scan

   logic [2:0] state_ff, state_in, after_ff, after_in;
   req_type    req_ff;
   rsp_type    out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   logic [5:0] trades_ff, trades_in;
   logic       adding_ff, adding_in;

   assign req_held  = req_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign req_ready = (state_ff == ST_IDLE) && !out_valid_ff;

   function automatic rsp_type status(input logic [2:0] k);
      rsp_type r;
      r = '0;
      r.kind = k;
      r.last = 1'b1;
      return r;
   endfunction

   always_comb begin
      state_in      = state_ff;
      after_in      = after_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      trades_in     = trades_ff;
      adding_in     = adding_ff;
      cmd_out       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd_out.scan_start = 1'b1;
               trades_in          = '0;
               state_in           = ST_SCAN1;
            end
         end
         ST_KICK: begin
            cmd_out.scan_start = 1'b1;
            state_in           = after_ff;
         end
         ST_SCAN1: begin
            if (sts_in.scan_done) begin
               case (req_ff.cmd)
                  CMD_ADD: begin
                     if (sts_in.id_found) begin
                        out_in = status(KIND_DUP); out_valid_in = 1'b1; state_in = ST_IDLE;
                     end else begin
                        adding_in = 1'b1; state_in = ST_SCAN2;
                     end
                  end
                  CMD_CANCEL: begin
                     out_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                     if (sts_in.id_found) begin
                        cmd_out.kill_found = 1'b1; out_in = status(KIND_DONE);
                     end else begin
                        out_in = status(KIND_UNKNOWN);
                     end
                  end
                  CMD_MODIFY: begin
                     if (sts_in.id_found) begin
                        cmd_out.kill_found  = 1'b1;
                        cmd_out.use_old_fok = 1'b1;
                        adding_in = 1'b0;
                        after_in  = ST_SCAN2;
                        state_in  = ST_KICK;
                     end else begin
                        out_in = status(KIND_UNKNOWN); out_valid_in = 1'b1; state_in = ST_IDLE;
                     end
                  end
                  default: begin
                     out_in = status(KIND_DONE); out_valid_in = 1'b1; state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCAN2: begin
            // add checks on an up-to-date scan
            if (sts_in.scan_done || adding_ff) begin
               adding_in = 1'b0;
               state_in  = ST_IDLE;
               out_valid_in = 1'b1;
               if (req_ff.quantity == 32'd0) begin
                  out_in = status(KIND_ZERO_QTY);
               end else if (sts_in.is_fok && !sts_in.fok_cross) begin
                  out_in = status(KIND_NO_CROSS);
               end else if (!sts_in.free_found) begin
                  out_in = status(KIND_FULL);
               end else begin
                  cmd_out.place = 1'b1;
                  out_valid_in  = 1'b0;
                  after_in      = ST_MATCH;
                  state_in      = ST_KICK;
               end
            end
         end
         ST_MATCH: begin
            if (sts_in.scan_done) begin
               if (sts_in.crossed && trades_ff != 6'(TRADE_CAP)) begin
                  cmd_out.trade = 1'b1;
                  trades_in     = trades_ff + 6'd1;
                  out_in        = trade_in;
                  out_valid_in  = 1'b1;
                  after_in      = ST_MATCH;
                  state_in      = ST_EMIT;
               end else begin
                  out_valid_in = 1'b1;
                  state_in     = ST_IDLE;
                  if (sts_in.is_fok && sts_in.new_valid) begin
                     cmd_out.kill_new = 1'b1; out_in = status(KIND_DONE_KILL);
                  end else begin
                     out_in = status(KIND_DONE);
                  end
               end
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_ready) state_in = ST_KICK;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         after_ff      <= ST_IDLE;
         out_valid_ff  <= 1'b0;
         trades_ff     <= '0;
         adding_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         after_ff      <= after_in;
         out_valid_ff  <= out_valid_in;
         trades_ff     <= trades_in;
         adding_ff     <= adding_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (req_valid && req_ready) req_ff <= req_in;
   end

endmodule

### rtl/limit_order_book_matcher.sv
// Top level of the limit order book matcher.
// Depends on lobm_pkg, lobm_control and lobm_datapath.
//
// Usage: commands (add, cancel, modify) enter on the req_ channel as one
// req_type struct under valid/ready; results leave on the rsp_ channel as
// rsp_type structs, zero or more trades followed by one status item with
// last set. One command is handled at a time.
// Each table sweep runs through the single serial scan unit (one registered
// table read a cycle), which looks up the id, the first free slot and best
// bid and ask in one pass. A cancel or rejected add answers after one sweep,
// and the next command can enter in the cycle after the status is taken. An
// accepted add needs two sweeps and a modify three, and each trade one more
// sweep.
// Matching stops after 63 trades per command.
// Reset (synchronous, active high) empties the book at once through the
// slot valid bits and clears the arrival counter.
// A stalled receiver holds the result register; the matcher waits before
// the next sweep and takes no new command until the status is taken.
module limit_order_book_matcher #(
   parameter int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lobm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lobm_pkg::rsp_type rsp_data
);
   import lobm_pkg::*;

   req_type    req_held;
   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;
   rsp_type    trade;

   lobm_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_in    (req_data),
      .req_held  (req_held),
      .cmd_out   (dp_cmd),
      .sts_in    (dp_sts),
      .trade_in  (trade),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   lobm_datapath #(.ORDER_SLOTS(ORDER_SLOTS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_in    (req_held),
      .cmd_in    (dp_cmd),
      .sts_out   (dp_sts),
      .trade_out (trade)
   );

endmodule

### test/limit_order_book_matcher_checker.sv
// Checker for the limit order book matcher: watches both channels, predicts
// the results of each accepted command and compares them. Depends on lobm_pkg.
module limit_order_book_matcher_checker #(
   parameter int SLOTS = lobm_pkg::ORDER_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  lobm_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  lobm_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count
);
   import lobm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FIFO_DEPTH = 1024;

   // Predicted book
   logic               bk_valid [SLOTS];
   logic [31:0]        bk_id    [SLOTS];
   logic               bk_sell  [SLOTS];
   logic               bk_fok   [SLOTS];
   logic signed [31:0] bk_price [SLOTS];
   logic [31:0]        bk_rem   [SLOTS];
   logic [31:0]        bk_stamp [SLOTS];
   logic [31:0]        stamp_ctr;

   rsp_type expected_fills [FIFO_DEPTH];
   int      wr_ptr = 0;
   int      rd_ptr = 0;
   int      batch_cnt;

   assign pending_count = wr_ptr - rd_ptr;

   function automatic void push_result(logic [2:0] k, logic [31:0] b, logic [31:0] a,
                                       logic [31:0] bp, logic [31:0] ap, logic [31:0] q,
                                       logic lst);
      rsp_type r;
      if (batch_cnt >= MAX_RESULTS) return;
      r.kind = k; r.bid_order_id = b; r.ask_order_id = a;
      r.bid_price = bp; r.ask_price = ap; r.fill_qty = q; r.last = lst;
      expected_fills[wr_ptr % FIFO_DEPTH] = r;
      wr_ptr++;
      batch_cnt++;
   endfunction

   function automatic void push_status(logic [2:0] k);
      push_result(k, '0, '0, '0, '0, '0, 1'b1);
   endfunction

   function automatic int lookup_id(logic [31:0] id);
      for (int i = 0; i < SLOTS; i++)
         if (bk_valid[i] && bk_id[i] == id) return i;
      return -1;
   endfunction

   // Best price first, then earliest stamp, then lowest slot
   function automatic int top_of_side(logic sell);
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (!bk_valid[i] || bk_sell[i] != sell) continue;
         if (best < 0) begin
            best = i;
            continue;
         end
         if (sell ? (bk_price[i] < bk_price[best]) : (bk_price[i] > bk_price[best]))
            best = i;
         else if (bk_price[i] == bk_price[best] && bk_stamp[i] < bk_stamp[best])
            best = i;
      end
      return best;
   endfunction

   function automatic void place_and_match(logic [31:0] id, logic sell, logic fok,
                                           logic signed [31:0] px, logic [31:0] qty);
      int opp, slot, b, a;
      logic [31:0] q;
      slot = -1;
      if (qty == 0) begin
         push_status(KIND_ZERO_QTY);
         return;
      end
      if (fok) begin
         opp = top_of_side(!sell);
         if (opp < 0 || (sell ? (px > bk_price[opp]) : (px < bk_price[opp]))) begin
            push_status(KIND_NO_CROSS);
            return;
         end
      end
      for (int i = 0; i < SLOTS; i++)
         if (!bk_valid[i]) begin
            slot = i;
            break;
         end
      if (slot < 0) begin
         push_status(KIND_FULL);
         return;
      end
      bk_valid[slot] = 1'b1; bk_id[slot] = id; bk_sell[slot] = sell;
      bk_fok[slot] = fok; bk_price[slot] = px; bk_rem[slot] = qty;
      bk_stamp[slot] = stamp_ctr;
      stamp_ctr++;
      // match best bid against best ask up to the trade cap
      while (batch_cnt < TRADE_CAP) begin
         b = top_of_side(1'b0);
         a = top_of_side(1'b1);
         if (b < 0 || a < 0) break;
         if (bk_price[b] < bk_price[a]) break;
         q = (bk_rem[b] < bk_rem[a]) ? bk_rem[b] : bk_rem[a];
         bk_rem[b] -= q;
         bk_rem[a] -= q;
         push_result(KIND_TRADE, bk_id[b], bk_id[a], bk_price[b], bk_price[a], q, 1'b0);
         if (bk_rem[b] == 0) bk_valid[b] = 1'b0;
         if (bk_rem[a] == 0) bk_valid[a] = 1'b0;
      end
      if (fok && bk_valid[slot]) begin
         bk_valid[slot] = 1'b0;
         push_status(KIND_DONE_KILL);
      end else begin
         push_status(KIND_DONE);
      end
   endfunction

   function automatic void predict_command(req_type c);
      int s;
      batch_cnt = 0;
      case (c.cmd)
         CMD_ADD: begin
            if (lookup_id(c.order_id) >= 0) push_status(KIND_DUP);
            else place_and_match(c.order_id, c.side, c.order_type, c.price, c.quantity);
         end
         CMD_CANCEL: begin
            s = lookup_id(c.order_id);
            if (s < 0) push_status(KIND_UNKNOWN);
            else begin
               bk_valid[s] = 1'b0;
               push_status(KIND_DONE);
            end
         end
         CMD_MODIFY: begin
            s = lookup_id(c.order_id);
            if (s < 0) push_status(KIND_UNKNOWN);
            else begin
               bk_valid[s] = 1'b0;
               place_and_match(c.order_id, c.side, bk_fok[s], c.price, c.quantity);
            end
         end
         default: push_status(KIND_DONE);
      endcase
   endfunction

   // Predict on each accepted command, compare each accepted result
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) bk_valid[i] = 1'b0;
         stamp_ctr  = '0;
         wr_ptr     = 0;
         rd_ptr     = 0;
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) predict_command(req_data);
         if (rsp_valid && rsp_ready) begin
            if (wr_ptr == rd_ptr) begin
               if (fail_count < 10)
                  $display("unexpected result transaction %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_fills[rd_ptr % FIFO_DEPTH];
               rd_ptr++;
               if (rsp_data !== want) begin
                  if (fail_count < 10)
                     $display("result mismatch: expected %p actual %p", want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

### test/limit_order_book_matcher_tb.sv
// Testbench top for the limit order book matcher: clock, reset, command
// stimulus and verdict. Depends on lobm_pkg and limit_order_book_matcher_checker.
module limit_order_book_matcher_tb;
   import lobm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   bit      calm_phase = 1'b0;
   int      idle_cycles = 0;
   logic [31:0] id_pool[16];

   always #2 clock = ~clock;

   limit_order_book_matcher i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   limit_order_book_matcher_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // Stall the result channel in random bursts
   initial begin
      int n;
      @(posedge clock iff !reset);
      forever begin
         rsp_ready <= 1'b1;
         n = $urandom_range(1, 30);
         repeat (n) @(posedge clock);
         if (!calm_phase && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 19);
            repeat (n) @(posedge clock);
         end
      end
   end

   // Watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("limit_order_book_matcher verification failed");
         $finish;
      end
   end

   task automatic send_command(logic [1:0] c, logic [31:0] id, logic sd, logic ft,
                               logic signed [31:0] px, logic [31:0] qty);
      int gap;
      req_type t;
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 19);
         repeat (gap) @(posedge clock);
      end
      t.cmd = c; t.order_id = id; t.side = sd; t.order_type = ft;
      t.price = px; t.quantity = qty;
      req_data  <= t;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Mostly well-formed traffic on a small id pool around a narrow price band
   task automatic random_command();
      logic [1:0] c;
      logic [31:0] id, qty;
      logic signed [31:0] px;
      int r;
      r = $urandom_range(0, 99);
      c = (r < 60) ? CMD_ADD : (r < 78) ? CMD_CANCEL : (r < 97) ? CMD_MODIFY : 2'd3;
      id = ($urandom_range(0, 19) == 0) ? $urandom() : id_pool[$urandom_range(0, 15)];
      r = $urandom_range(0, 19);
      px = (r == 0) ? $signed($urandom()) : 100 + $signed($urandom_range(0, 10)) - 5;
      r = $urandom_range(0, 19);
      qty = (r == 0) ? 32'd0 : (r == 1) ? $urandom() : $urandom_range(1, 50);
      send_command(c, id, $urandom_range(0, 1), $urandom_range(0, 3) == 0, px, qty);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 16; i++) id_pool[i] = $urandom();
      id_pool[0] = 32'd0;
      id_pool[1] = 32'hFFFF_FFFF;

      // Directed: extremes, every command, each rejection path
      send_command(CMD_ADD, 32'd0, 1'b0, 1'b0, 32'sh8000_0000, 32'hFFFF_FFFF);
      send_command(CMD_ADD, 32'd0, 1'b1, 1'b0, 32'sd5, 32'd1);            // duplicate
      send_command(CMD_ADD, 32'd7, 1'b1, 1'b0, 32'sd5, 32'd0);            // zero quantity
      send_command(CMD_ADD, 32'd8, 1'b0, 1'b1, 32'sd5, 32'd3);            // fok, no sell side
      send_command(CMD_ADD, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'sh7FFF_FFFF, 32'd10);
      send_command(CMD_ADD, 32'd9, 1'b0, 1'b1, 32'sh7FFF_FFFE, 32'd5);    // fok below ask
      send_command(CMD_ADD, 32'd9, 1'b0, 1'b1, 32'sh7FFF_FFFF, 32'd4);    // fok fully filled
      send_command(CMD_ADD, 32'd10, 1'b0, 1'b1, 32'sh7FFF_FFFF, 32'd20);  // fok residual killed
      send_command(CMD_CANCEL, 32'd1234, 1'b0, 1'b0, 32'sd0, 32'd0);      // unknown cancel
      send_command(CMD_MODIFY, 32'd1234, 1'b0, 1'b0, 32'sd0, 32'd1);      // unknown modify
      send_command(CMD_MODIFY, 32'd0, 1'b0, 1'b0, 32'sh7FFF_FFFF, 32'd2); // modify, no ask to cross
      send_command(CMD_MODIFY, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'sd1, 32'd0); // modify rejected
      send_command(2'd3, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
      send_command(CMD_CANCEL, 32'd0, 1'b0, 1'b0, 32'sd0, 32'd0);
      // Fill the book, overflow it, then match one large sell against it up to the trade cap
      for (int i = 0; i < 65; i++)
         send_command(CMD_ADD, 32'd1000 + i, 1'b0, 1'b0, 32'sd50 + (i % 3), 32'd1);
      send_command(CMD_ADD, 32'd2000, 1'b1, 1'b0, 32'sd0, 32'd100);
      send_command(CMD_CANCEL, 32'd2000, 1'b0, 1'b0, 32'sd0, 32'd0);

      // Hold until every expected result has arrived
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);

      for (int n = 0; n < 180; n++) begin
         if (n == 150) calm_phase = 1'b1;
         random_command();
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("limit_order_book_matcher verification clean");
      else
         $display("limit_order_book_matcher verification failed");
      $finish;
   end
endmodule
